@@ hw/rtl/i2r_pkg.sv @@
// i2r_pkg: types, symbol codes and digit helpers for the integer to roman numeral block
// used by every module of the block; depends on nothing
package i2r_pkg;

	localparam int VALUE_W = 14;
	localparam int SYM_W = 7;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [SYM_W-1:0] SYM_NONE = 7'h00;
	localparam logic [SYM_W-1:0] SYM_I = 7'h49;
	localparam logic [SYM_W-1:0] SYM_V = 7'h56;
	localparam logic [SYM_W-1:0] SYM_X = 7'h58;
	localparam logic [SYM_W-1:0] SYM_L = 7'h4C;
	localparam logic [SYM_W-1:0] SYM_C = 7'h43;
	localparam logic [SYM_W-1:0] SYM_D = 7'h44;
	localparam logic [SYM_W-1:0] SYM_M = 7'h4D;

	localparam logic [1:0] PLACE_ONES = 2'd0;
	localparam logic [1:0] PLACE_TENS = 2'd1;
	localparam logic [1:0] PLACE_HUNDREDS = 2'd2;
	localparam logic [1:0] PLACE_THOUSANDS = 2'd3;

	localparam logic [VALUE_W-1:0] UNIT_TH = 14'd1000;
	localparam logic [VALUE_W-1:0] UNIT_HU = 14'd100;
	localparam logic [VALUE_W-1:0] UNIT_TE = 14'd10;
	localparam logic [4:0] MAX_M = 5'd3;

	// one decimal digit per place, index 3 is thousands (already limited to 0..3)
	typedef struct packed {
		logic [3:0][3:0] dig;
	} desc_t;

	typedef struct packed {
		logic [4:0] digit;
		logic [VALUE_W-1:0] rem;
	} dstep_t;

	// restoring divide of a value by a constant unit, quotient below 32
	function automatic dstep_t div_step(input logic [VALUE_W-1:0] r,
		input logic [VALUE_W-1:0] unit);
		logic [VALUE_W:0] acc;
		logic [VALUE_W:0] trial;
		dstep_t res;
		acc = {1'b0, r};
		res.digit = '0;
		for (int k = 4; k >= 0; k--) begin
			trial = {1'b0, unit} << k;
			if (acc >= trial) begin
				acc = acc - trial;
				res.digit[k] = 1'b1;
			end
		end
		res.rem = acc[VALUE_W-1:0];
		return res;
	endfunction

	// number of symbols a digit takes
	function automatic logic [2:0] n_sym(input logic [3:0] d);
		logic [2:0] n;
		case (d) inside
			[4'd1:4'd3]: n = d[2:0];
			4'd4: n = 3'd2;
			[4'd5:4'd8]: n = 3'(d - 4'd4);
			4'd9: n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// symbol at a given position inside one digit's run
	function automatic logic [SYM_W-1:0] sym_at(input logic [3:0] d, input logic [1:0] place,
		input logic [1:0] pos);
		logic [SYM_W-1:0] lo;
		logic [SYM_W-1:0] mi;
		logic [SYM_W-1:0] hi;
		logic [SYM_W-1:0] s;
		case (place)
			PLACE_ONES: begin
				lo = SYM_I; mi = SYM_V; hi = SYM_X;
			end
			PLACE_TENS: begin
				lo = SYM_X; mi = SYM_L; hi = SYM_C;
			end
			PLACE_HUNDREDS: begin
				lo = SYM_C; mi = SYM_D; hi = SYM_M;
			end
			default: begin
				lo = SYM_M; mi = SYM_M; hi = SYM_M;
			end
		endcase
		case (d) inside
			4'd4: s = (pos == 2'd0) ? lo : mi;
			[4'd5:4'd8]: s = (pos == 2'd0) ? mi : lo;
			4'd9: s = (pos == 2'd0) ? lo : hi;
			default: s = lo;
		endcase
		return s;
	endfunction

endpackage

@@ hw/rtl/i2r_in_if.sv @@
// i2r_in_if: input channel of the roman numeral block, one integer per transfer
// depends on i2r_pkg
interface i2r_in_if;
	logic valid;
	logic ready;
	logic [i2r_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

@@ hw/rtl/i2r_out_if.sv @@
// i2r_out_if: result channel of the roman numeral block, one symbol per transfer
// depends on i2r_pkg
interface i2r_out_if;
	logic valid;
	logic ready;
	logic [i2r_pkg::SYM_W-1:0] symbol;
	logic last;
	logic empty_res;

	modport source (output valid, output symbol, output last, output empty_res, input ready);
	modport sink (input valid, input symbol, input last, input empty_res, output ready);
endinterface

@@ hw/rtl/integer_to_roman_numeral.sv @@
// Integer to roman numeral converter.
// din carries one unsigned 14-bit value per transfer (valid/ready); dout carries
// the numeral as ASCII symbols (I V X L C D M), most significant first, one per
// transfer, with last set on the final symbol. A thousands digit of 4 or more
// gives no M. A numeral with no symbols comes out as one transfer with symbol 0,
// last 1 and empty_res 1.
// The front takes a value, then works through the thousands, hundreds and tens
// digits, one compare-subtract chain per cycle unless the queue is full, and takes
// no new value until it pushes the descriptor. A queue of QUEUE_DEPTH descriptors
// sits between front and back. The back writes one symbol per cycle, while dout is
// not stalled, into the output register: max(1, symbol count) per value, at most 15.
// A value passes ST_TH, ST_HU, ST_TE, the queue and the output register before dout
// valid rises. When dout stalls the output register holds, the back waits, the queue
// fills and then din deasserts ready. Reset clears the front, queue and output valid.
module integer_to_roman_numeral #(
	parameter int QUEUE_DEPTH = i2r_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	i2r_in_if.sink din,
	i2r_out_if.source dout
);
	import i2r_pkg::*;

	logic push_valid;
	logic push_ready;
	desc_t push_desc;
	logic head_valid;
	logic pop;
	desc_t head_desc;

	i2r_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.din(din),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_desc(push_desc)
	);

	i2r_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_desc(push_desc),
		.head_valid(head_valid),
		.pop(pop),
		.head_desc(head_desc)
	);

	i2r_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_desc(head_desc),
		.pop(pop),
		.dout(dout)
	);
endmodule

@@ hw/rtl/i2r_front.sv @@
// i2r_front: accepts an integer and splits it into decimal digits, one place per cycle unless the queue is full
// depends on i2r_pkg and i2r_in_if
module i2r_front (
	input logic clk,
	input logic arst_n,
	i2r_in_if.sink din,
	output logic push_valid,
	input logic push_ready,
	output i2r_pkg::desc_t push_desc
);
	import i2r_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TH = 2'd1;
	localparam logic [1:0] ST_HU = 2'd2;
	localparam logic [1:0] ST_TE = 2'd3;

	logic [1:0] state_q;
	logic [VALUE_W-1:0] rem_q;
	logic [3:0] th_q;
	logic [3:0] hu_q;
	dstep_t step;
	logic [VALUE_W-1:0] unit;

	assign din.ready = (state_q == ST_IDLE);

	always_comb begin
		case (state_q)
			ST_TH: unit = UNIT_TH;
			ST_HU: unit = UNIT_HU;
			default: unit = UNIT_TE;
		endcase
		step = div_step(rem_q, unit);
	end

	assign push_valid = (state_q == ST_TE);
	assign push_desc.dig[3] = th_q;
	assign push_desc.dig[2] = hu_q;
	assign push_desc.dig[1] = step.digit[3:0];
	assign push_desc.dig[0] = step.rem[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (din.valid) state_q <= ST_TH;
				ST_TH: state_q <= ST_HU;
				ST_HU: state_q <= ST_TE;
				ST_TE: if (push_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (din.valid) rem_q <= din.value;
			end
			ST_TH: begin
				// thousands of four or more give no M
				th_q <= (step.digit != 5'd0 && step.digit <= MAX_M) ? step.digit[3:0] : 4'd0;
				rem_q <= step.rem;
			end
			ST_HU: begin
				hu_q <= step.digit[3:0];
				rem_q <= step.rem;
			end
			default: begin
			end
		endcase
	end
endmodule

@@ hw/rtl/i2r_queue.sv @@
// i2r_queue: short queue of digit descriptors between front and back
// depends on i2r_pkg
module i2r_queue #(
	parameter int DEPTH = i2r_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input i2r_pkg::desc_t push_desc,
	output logic head_valid,
	input logic pop,
	output i2r_pkg::desc_t head_desc
);
	import i2r_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	desc_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_desc = entries_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= push_desc;
	end
endmodule

@@ hw/rtl/i2r_back.sv @@
// i2r_back: expands the queue head into roman symbols, one per cycle unless dout stalls, into an output register
// depends on i2r_pkg and i2r_out_if
module i2r_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input i2r_pkg::desc_t head_desc,
	output logic pop,
	i2r_out_if.source dout
);
	import i2r_pkg::*;

	logic started_q;
	logic [3:0] mask_q;
	logic [1:0] pos_q;
	logic out_valid_q;
	logic [SYM_W-1:0] sym_q;
	logic last_q;
	logic empty_q;

	logic [3:0] nz;
	logic [3:0] cur_mask;
	logic [1:0] place;
	logic [3:0] cur_dig;
	logic [2:0] n_cur;
	logic digit_done;
	logic [3:0] rest;
	logic is_empty;
	logic is_last;
	logic emit;

	always_comb begin
		for (int p = 0; p < 4; p++) nz[p] = (n_sym(head_desc.dig[p]) != 3'd0);
		cur_mask = started_q ? mask_q : nz;
		if (cur_mask[3]) place = PLACE_THOUSANDS;
		else if (cur_mask[2]) place = PLACE_HUNDREDS;
		else if (cur_mask[1]) place = PLACE_TENS;
		else place = PLACE_ONES;
		cur_dig = head_desc.dig[place];
		n_cur = n_sym(cur_dig);
		digit_done = (({1'b0, pos_q} + 3'd1) == n_cur);
		rest = cur_mask & ~(4'b0001 << place);
		is_empty = (cur_mask == 4'd0);
		is_last = is_empty || (digit_done && rest == 4'd0);
	end

	assign emit = head_valid && (!out_valid_q || dout.ready);
	assign pop = emit && is_last;

	assign dout.valid = out_valid_q;
	assign dout.symbol = sym_q;
	assign dout.last = last_q;
	assign dout.empty_res = empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			mask_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				if (is_last) begin
					started_q <= 1'b0;
					pos_q <= '0;
				end else if (digit_done) begin
					started_q <= 1'b1;
					mask_q <= rest;
					pos_q <= '0;
				end else begin
					started_q <= 1'b1;
					mask_q <= cur_mask;
					pos_q <= pos_q + 1'b1;
				end
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sym_q <= is_empty ? SYM_NONE : sym_at(cur_dig, place, pos_q);
			last_q <= is_last;
			empty_q <= is_empty;
		end
	end
endmodule
